/* design/priority_slice_task_scheduler_defines.svh */
// Assertion macros for the scheduler checker.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef PRIORITY_SLICE_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_SLICE_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pst_pkg.sv */
`default_nettype none

package pst_pkg;

  localparam int SLOTS   = 256;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int PID_W   = 9;
  localparam int PRIO_W  = 8;
  localparam int TICK_W  = 32;
  localparam int SLICE_W = 8;
  localparam int CNT_W   = 9;

  localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(SLOTS - 1);
  localparam logic [SLICE_W-1:0] DEFAULT_SLICE = SLICE_W'(100);
  localparam logic [PRIO_W-1:0]  IDLE_PRIO     = PRIO_W'(255);
  localparam logic [PID_W-1:0]   IDLE_PID      = PID_W'(1);
  localparam logic [PID_W-1:0]   FIRST_ID      = PID_W'(2);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_EXIT   = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_ZOMBIE  = 3'd4
  } slot_st_t;

  // One slot of the task table (run ticks live in a memory of their own).
  typedef struct packed {
    slot_st_t          st;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } row_t;

  // Write side of the task table.
  typedef struct packed {
    logic             row_we;
    logic             ticks_we;
    logic [IDX_W-1:0] addr;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* design/priority_slice_task_scheduler.sv */
// A tick that only counts down the slice reads the current slot (S_CURRD), updates it
// (S_CUREVAL) and goes to S_DONE; create, exit, start and dispatching ticks make one full
// pass over the slot table through its single read port (S_SCAN, S_DRAIN, S_COMMIT).
// One item is taken at a time; S_DONE waits until the output register is free, and results
// wait there so the next transfer can start. After reset a clearing pass writes the table
// with in_ready low; cfg writes are taken at any time.
`default_nettype none

module priority_slice_task_scheduler import pst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic [PID_W-1:0]   in_pid,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [PID_W-1:0]   out_new_pid,
  output logic               out_switched,
  output logic               out_running_valid,
  output logic [PID_W-1:0]   out_running_pid,
  output logic [PRIO_W-1:0]  out_running_priority,
  output logic [CNT_W-1:0]   out_used_count,
  // configuration: slice length
  input  logic               cfg_we,
  input  logic [SLICE_W-1:0] cfg_wdata
);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,  // post-reset sweep writing reset values
    S_IDLE    = 8'b0000_0010,  // wait for a transfer
    S_CURRD   = 8'b0000_0100,  // read the current slot
    S_CUREVAL = 8'b0000_1000,  // count ticks, slice countdown, requeue
    S_SCAN    = 8'b0001_0000,  // one slot read per cycle
    S_DRAIN   = 8'b0010_0000,  // compare the last slot read
    S_COMMIT  = 8'b0100_0000,  // write back the scan winner
    S_DONE    = 8'b1000_0000   // hand the result to the output register
  } fsm_t;

  fsm_t               state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [PID_W-1:0]   best_pid_r, best_pid_nxt;
  logic [PRIO_W-1:0]  best_prio_r, best_prio_nxt;
  logic               expire_r, expire_nxt;

  op_t                op_r, op_nxt;
  logic [PRIO_W-1:0]  prio_req_r, prio_req_nxt;
  logic [PID_W-1:0]   pid_req_r, pid_req_nxt;

  logic               cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic [PID_W-1:0]   cur_pid_r, cur_pid_nxt;
  logic [PRIO_W-1:0]  cur_prio_r, cur_prio_nxt;
  logic [SLICE_W-1:0] slice_left_r, slice_left_nxt;
  logic [PID_W-1:0]   next_id_r, next_id_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [SLICE_W-1:0] slice_len_r, slice_len_nxt;

  status_t            status_r, status_nxt;
  logic [PID_W-1:0]   new_pid_r, new_pid_nxt;
  logic               switched_r, switched_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [PID_W-1:0]   out_new_pid_r, out_new_pid_nxt;
  logic               out_switched_r, out_switched_nxt;
  logic               out_run_vld_r, out_run_vld_nxt;
  logic [PID_W-1:0]   out_run_pid_r, out_run_pid_nxt;
  logic [PRIO_W-1:0]  out_run_prio_r, out_run_prio_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;

  // Table ports.
  tbl_wr_t            tbl_wr;
  row_t               row_wdata;
  logic [TICK_W-1:0]  ticks_wdata;
  logic [IDX_W-1:0]   tbl_raddr;
  row_t               tbl_rd_row;
  logic [TICK_W-1:0]  tbl_rd_ticks;

  logic               hit;

  pst_table u_table (
    .clk        (clk),
    .wr         (tbl_wr),
    .row_wdata  (row_wdata),
    .ticks_wdata(ticks_wdata),
    .raddr      (tbl_raddr),
    .rd_row_r   (tbl_rd_row),
    .rd_ticks_r (tbl_rd_ticks)
  );

  assign in_ready = (state_r == S_IDLE);

  // Scan compare: the shared unit applied to the slot read in the previous cycle.
  //  dispatch (tick, start): ready slot with the strictly lower priority number wins,
  //                          so ties stay with the lower index
  //  create: first unused slot
  //  exit:   first used slot carrying the requested id
  always_comb begin
    case (op_r)
      OP_CREATE: hit = (tbl_rd_row.st == ST_UNUSED) && !found_r;
      OP_EXIT:   hit = (tbl_rd_row.st != ST_UNUSED) && (tbl_rd_row.pid == pid_req_r) &&
                       !found_r;
      default:   hit = (tbl_rd_row.st == ST_READY) &&
                       (!found_r || (tbl_rd_row.prio < best_prio_r));
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    rd_vld_nxt       = 1'b0;
    rd_idx_nxt       = rd_idx_r;
    found_nxt        = found_r;
    best_idx_nxt     = best_idx_r;
    best_pid_nxt     = best_pid_r;
    best_prio_nxt    = best_prio_r;
    expire_nxt       = expire_r;
    op_nxt           = op_r;
    prio_req_nxt     = prio_req_r;
    pid_req_nxt      = pid_req_r;
    cur_valid_nxt    = cur_valid_r;
    cur_slot_nxt     = cur_slot_r;
    cur_pid_nxt      = cur_pid_r;
    cur_prio_nxt     = cur_prio_r;
    slice_left_nxt   = slice_left_r;
    next_id_nxt      = next_id_r;
    used_nxt         = used_r;
    slice_len_nxt    = slice_len_r;
    status_nxt       = status_r;
    new_pid_nxt      = new_pid_r;
    switched_nxt     = switched_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_new_pid_nxt  = out_new_pid_r;
    out_switched_nxt = out_switched_r;
    out_run_vld_nxt  = out_run_vld_r;
    out_run_pid_nxt  = out_run_pid_r;
    out_run_prio_nxt = out_run_prio_r;
    out_used_nxt     = out_used_r;

    tbl_wr      = '0;
    row_wdata   = tbl_rd_row;
    ticks_wdata = '0;
    tbl_raddr   = idx_r;

    // Record the scan winner so far.
    if (rd_vld_r && hit) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = rd_idx_r;
      best_pid_nxt  = tbl_rd_row.pid;
      best_prio_nxt = tbl_rd_row.prio;
    end

    if (cfg_we) begin
      slice_len_nxt = cfg_wdata;
    end

    // Drop the result once it is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // Slot zero holds the idle task; every other slot starts unused.
        tbl_wr.row_we   = 1'b1;
        tbl_wr.ticks_we = 1'b1;
        tbl_wr.addr     = idx_r;
        if (idx_r == '0) begin
          row_wdata = '{st: ST_READY, pid: IDLE_PID, prio: IDLE_PRIO};
        end else begin
          row_wdata = '{st: ST_UNUSED, pid: '0, prio: '0};
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_op);
          prio_req_nxt = in_priority_req;
          pid_req_nxt  = in_pid;
          status_nxt   = STAT_OK;
          new_pid_nxt  = '0;
          switched_nxt = 1'b0;
          found_nxt    = 1'b0;
          expire_nxt   = 1'b0;
          idx_nxt      = '0;
          // Ticks and starts with a task current look at that slot first.
          if (((op_t'(in_op) == OP_TICK) || (op_t'(in_op) == OP_START)) && cur_valid_r) begin
            state_nxt = S_CURRD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_CURRD: begin
        tbl_raddr = cur_slot_r;
        state_nxt = S_CUREVAL;
      end

      S_CUREVAL: begin
        tbl_wr.addr = cur_slot_r;
        row_wdata.st = ST_READY;
        if (op_r == OP_TICK) begin
          // Count run time, then either burn one slice tick or expire.
          tbl_wr.ticks_we = 1'b1;
          ticks_wdata     = tbl_rd_ticks + TICK_W'(1);
          if (slice_left_r != '0) begin
            slice_left_nxt = slice_left_r - SLICE_W'(1);
            state_nxt      = S_DONE;
          end else begin
            // A zombie stays a zombie at expiry.
            expire_nxt    = 1'b1;
            tbl_wr.row_we = (tbl_rd_row.st != ST_ZOMBIE);
            state_nxt     = S_SCAN;
          end
        end else begin
          // Start: requeue a running task so it competes in the pick.
          tbl_wr.row_we = (tbl_rd_row.st == ST_RUNNING);
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        tbl_raddr  = idx_r;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end

      S_COMMIT: begin
        tbl_wr.addr = best_idx_r;
        case (op_r)
          OP_CREATE: begin
            if (found_r) begin
              tbl_wr.row_we   = 1'b1;
              tbl_wr.ticks_we = 1'b1;
              row_wdata       = '{st: ST_READY, pid: next_id_r, prio: prio_req_r};
              new_pid_nxt     = next_id_r;
              next_id_nxt     = next_id_r + PID_W'(1);
              used_nxt        = used_r + CNT_W'(1);
            end else begin
              status_nxt = STAT_FULL;
            end
          end
          OP_EXIT: begin
            if (found_r) begin
              tbl_wr.row_we = 1'b1;
              row_wdata     = '{st: ST_ZOMBIE, pid: best_pid_r, prio: best_prio_r};
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
          end
          default: begin
            if (found_r) begin
              tbl_wr.row_we  = 1'b1;
              row_wdata      = '{st: ST_RUNNING, pid: best_pid_r, prio: best_prio_r};
              cur_valid_nxt  = 1'b1;
              cur_slot_nxt   = best_idx_r;
              cur_pid_nxt    = best_pid_r;
              cur_prio_nxt   = best_prio_r;
              slice_left_nxt = slice_len_r;
              switched_nxt   = 1'b1;
            end else if (expire_r) begin
              // Expired with nothing ready: the processor goes idle.
              cur_valid_nxt = 1'b0;
            end
          end
        endcase
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = status_r;
          out_new_pid_nxt  = new_pid_r;
          out_switched_nxt = switched_r;
          out_run_vld_nxt  = cur_valid_r;
          out_run_pid_nxt  = cur_valid_r ? cur_pid_r : '0;
          out_run_prio_nxt = cur_valid_r ? cur_prio_r : '0;
          out_used_nxt     = used_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      expire_r     <= 1'b0;
      cur_valid_r  <= 1'b0;
      cur_slot_r   <= '0;
      slice_left_r <= DEFAULT_SLICE;
      next_id_r    <= FIRST_ID;
      used_r       <= CNT_W'(1);
      slice_len_r  <= DEFAULT_SLICE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      expire_r     <= expire_nxt;
      cur_valid_r  <= cur_valid_nxt;
      cur_slot_r   <= cur_slot_nxt;
      slice_left_r <= slice_left_nxt;
      next_id_r    <= next_id_nxt;
      used_r       <= used_nxt;
      slice_len_r  <= slice_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    rd_idx_r       <= rd_idx_nxt;
    best_idx_r     <= best_idx_nxt;
    best_pid_r     <= best_pid_nxt;
    best_prio_r    <= best_prio_nxt;
    op_r           <= op_nxt;
    prio_req_r     <= prio_req_nxt;
    pid_req_r      <= pid_req_nxt;
    cur_pid_r      <= cur_pid_nxt;
    cur_prio_r     <= cur_prio_nxt;
    status_r       <= status_nxt;
    new_pid_r      <= new_pid_nxt;
    switched_r     <= switched_nxt;
    out_status_r   <= out_status_nxt;
    out_new_pid_r  <= out_new_pid_nxt;
    out_switched_r <= out_switched_nxt;
    out_run_vld_r  <= out_run_vld_nxt;
    out_run_pid_r  <= out_run_pid_nxt;
    out_run_prio_r <= out_run_prio_nxt;
    out_used_r     <= out_used_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_new_pid          = out_new_pid_r;
  assign out_switched         = out_switched_r;
  assign out_running_valid    = out_run_vld_r;
  assign out_running_pid      = out_run_pid_r;
  assign out_running_priority = out_run_prio_r;
  assign out_used_count       = out_used_r;

endmodule

`default_nettype wire

/* design/pst_table.sv */
`default_nettype none

module pst_table import pst_pkg::*; (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  row_t              row_wdata,
  input  logic [TICK_W-1:0] ticks_wdata,
  input  logic [IDX_W-1:0]  raddr,
  output row_t              rd_row_r,
  output logic [TICK_W-1:0] rd_ticks_r
);

  row_t              row_mem   [SLOTS];
  logic [TICK_W-1:0] ticks_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.row_we) begin
      row_mem[wr.addr] <= row_wdata;
    end
    if (wr.ticks_we) begin
      ticks_mem[wr.addr] <= ticks_wdata;
    end
    rd_row_r   <= row_mem[raddr];
    rd_ticks_r <= ticks_mem[raddr];
  end

endmodule

`default_nettype wire

/* design/pst_checker.sv */
`default_nettype none
`include "priority_slice_task_scheduler_defines.svh"

module pst_checker import pst_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         in_op,
  input wire logic [PRIO_W-1:0]  in_priority_req,
  input wire logic [PID_W-1:0]   in_pid,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic [PID_W-1:0]   out_new_pid,
  input wire logic               out_switched,
  input wire logic               out_running_valid,
  input wire logic [PID_W-1:0]   out_running_pid,
  input wire logic [PRIO_W-1:0]  out_running_priority,
  input wire logic [CNT_W-1:0]   out_used_count,
  input wire logic               cfg_we,
  input wire logic [SLICE_W-1:0] cfg_wdata
);

  // A stalled result holds.
  `PST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_new_pid) && $stable(out_running_pid) && $stable(out_used_count), "stalled result changed")

  // One item at a time: busy right after a transfer.
  `PST_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")

  // A failed create or exit neither assigns an id nor dispatches.
  `PST_ASSERT_IMPL(a_err_quiet, out_valid && (out_status != STAT_OK), (out_new_pid == '0) && !out_switched, "error result has side effects")

  // No task running: id and priority read zero and nothing was dispatched.
  `PST_ASSERT_IMPL(a_idle_zero, out_valid && !out_running_valid, (out_running_pid == '0) && (out_running_priority == '0) && !out_switched, "idle result not cleared")

  // The idle task slot is never released.
  `PST_ASSERT_IMPL(a_used_nonzero, out_valid, out_used_count != '0, "used count reached zero")

endmodule

bind priority_slice_task_scheduler pst_checker u_pst_checker (.*);

`default_nettype wire

/* tb/sched_reply_scoreboard.sv */
`default_nettype none

module sched_reply_scoreboard import pst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic [PID_W-1:0]   in_pid,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [PID_W-1:0]   out_new_pid,
  input  logic               out_switched,
  input  logic               out_running_valid,
  input  logic [PID_W-1:0]   out_running_pid,
  input  logic [PRIO_W-1:0]  out_running_priority,
  input  logic [CNT_W-1:0]   out_used_count,
  input  logic               cfg_we,
  input  logic [SLICE_W-1:0] cfg_wdata,
  output int                 pending,
  output int                 fail_count
);

  typedef struct packed {
    logic [1:0]        status;
    logic [PID_W-1:0]  new_pid;
    logic              switched;
    logic              run_valid;
    logic [PID_W-1:0]  run_pid;
    logic [PRIO_W-1:0] run_prio;
    logic [CNT_W-1:0]  used;
  } sched_reply_t;

  // Shadow copy of the task table and the dispatcher state.
  slot_st_t          tbl_state [SLOTS];
  logic [PID_W-1:0]  tbl_pid   [SLOTS];
  logic [PRIO_W-1:0] tbl_prio  [SLOTS];
  logic              cur_valid;
  int unsigned       cur_slot;
  logic [SLICE_W-1:0] slice_left;
  logic [SLICE_W-1:0] slice_len;
  logic [PID_W-1:0]  next_id;
  logic [CNT_W-1:0]  used_cnt;

  sched_reply_t expected_replies [$];

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = ST_UNUSED;
      tbl_pid[i]   = '0;
      tbl_prio[i]  = '0;
    end
    tbl_state[0] = ST_READY;
    tbl_pid[0]   = IDLE_PID;
    tbl_prio[0]  = IDLE_PRIO;
    cur_valid    = 1'b0;
    cur_slot     = 0;
    slice_left   = DEFAULT_SLICE;
    slice_len    = DEFAULT_SLICE;
    next_id      = FIRST_ID;
    used_cnt     = CNT_W'(1);
  endfunction

  // Pick the best ready slot, lowest index on ties, and make it current.
  function automatic bit dispatch_best();
    bit found;
    int unsigned best;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[i] == ST_READY && (!found || tbl_prio[i] < tbl_prio[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      cur_valid       = 1'b1;
      cur_slot        = best;
      tbl_state[best] = ST_RUNNING;
      slice_left      = slice_len;
    end
    return found;
  endfunction

  function automatic sched_reply_t apply_request(op_t op, logic [PRIO_W-1:0] prio,
                                                 logic [PID_W-1:0] id);
    sched_reply_t r;
    bit done;
    bit any_ready;
    r    = '0;
    done = 1'b0;
    r.status = STAT_OK;
    case (op)
      OP_TICK: begin
        if (!cur_valid) begin
          r.switched = dispatch_best();
        end else if (slice_left > 0) begin
          slice_left = slice_left - 1'b1;
        end else begin
          if (tbl_state[cur_slot] != ST_ZOMBIE) tbl_state[cur_slot] = ST_READY;
          if (dispatch_best()) r.switched = 1'b1;
          else cur_valid = 1'b0;
        end
      end
      OP_CREATE: begin
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (tbl_state[i] == ST_UNUSED) begin
            tbl_state[i] = ST_READY;
            tbl_pid[i]   = next_id;
            tbl_prio[i]  = prio;
            r.new_pid    = next_id;
            next_id      = next_id + 1'b1;
            used_cnt     = used_cnt + 1'b1;
            done         = 1'b1;
          end
        end
        if (!done) r.status = STAT_FULL;
      end
      OP_EXIT: begin
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == id) begin
            tbl_state[i] = ST_ZOMBIE;
            done         = 1'b1;
          end
        end
        if (!done) r.status = STAT_NOT_FOUND;
      end
      default: begin
        any_ready = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_state[i] == ST_READY) any_ready = 1'b1;
        if (cur_valid && tbl_state[cur_slot] == ST_RUNNING) begin
          tbl_state[cur_slot] = ST_READY;
          any_ready = 1'b1;
        end
        if (any_ready) r.switched = dispatch_best();
      end
    endcase
    r.run_valid = cur_valid;
    r.run_pid   = cur_valid ? tbl_pid[cur_slot] : '0;
    r.run_prio  = cur_valid ? tbl_prio[cur_slot] : '0;
    r.used      = used_cnt;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_reply_t want;
    if (!rst_n) begin
      clear_table();
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) slice_len = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, out_status);
          check_field("new_pid", want.new_pid, out_new_pid);
          check_field("switched", want.switched, out_switched);
          check_field("running_valid", want.run_valid, out_running_valid);
          check_field("running_pid", want.run_pid, out_running_pid);
          check_field("running_priority", want.run_prio, out_running_priority);
          check_field("used_count", want.used, out_used_count);
        end
      end
      if (in_valid && in_ready)
        expected_replies.push_back(apply_request(op_t'(in_op), in_priority_req, in_pid));
    end
    pending <= expected_replies.size();
  end

endmodule

`default_nettype wire

/* tb/tb_priority_slice_task_scheduler.sv */
`default_nettype none

module tb_priority_slice_task_scheduler;
  import pst_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic [PRIO_W-1:0]  in_priority_req;
  logic [PID_W-1:0]   in_pid;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [PID_W-1:0]   out_new_pid;
  logic               out_switched;
  logic               out_running_valid;
  logic [PID_W-1:0]   out_running_pid;
  logic [PRIO_W-1:0]  out_running_priority;
  logic [CNT_W-1:0]   out_used_count;
  logic               cfg_we;
  logic [SLICE_W-1:0] cfg_wdata;

  int pending;
  int fail_count;

  // Idle controls for both sides; phases switch them off for back-to-back stretches.
  bit tx_gaps_on  = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_hold     = 0;
  // Creates sent so far; bounds the ids that exit requests aim at.
  int created     = 0;

  priority_slice_task_scheduler dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_priority_req      (in_priority_req),
    .in_pid               (in_pid),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_new_pid          (out_new_pid),
    .out_switched         (out_switched),
    .out_running_valid    (out_running_valid),
    .out_running_pid      (out_running_pid),
    .out_running_priority (out_running_priority),
    .out_used_count       (out_used_count),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  sched_reply_scoreboard scoreboard (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_priority_req      (in_priority_req),
    .in_pid               (in_pid),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_new_pid          (out_new_pid),
    .out_switched         (out_switched),
    .out_running_valid    (out_running_valid),
    .out_running_pid      (out_running_pid),
    .out_running_priority (out_running_priority),
    .out_used_count       (out_used_count),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .pending              (pending),
    .fail_count           (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: drop out_ready for a random stretch now and then.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_stall_on && $urandom_range(0, 99) < 25) rx_hold = pick_gap(1'b1);
    end
  end

  // Present one request and hold it until the transfer happens.
  task automatic push(op_t op, logic [PRIO_W-1:0] prio, logic [PID_W-1:0] id);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_priority_req <= prio;
    in_pid          <= id;
    if (op == OP_CREATE) created++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and hold until every outstanding result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Per-phase slice length, item count and op mix in percent (start takes the rest).
  int ph_slice  [8] = '{3, 0, 1, 255, 2, 0, 0, 100};
  int ph_items  [8] = '{150, 150, 150, 300, 150, 150, 150, 150};
  int ph_tick   [8] = '{50, 55, 40, 93, 55, 60, 50, 55};
  int ph_create [8] = '{30, 20, 45, 4, 25, 20, 30, 20};
  int ph_exit   [8] = '{10, 15, 10, 3, 12, 12, 12, 15};

  initial begin
    int r;
    int id_hi;
    int waited;
    op_t op;
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0] id;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_TICK;
    in_priority_req = '0;
    in_pid          = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset slice length first.
    push(OP_TICK,   8'd0,   9'd0);    // idle tick picks the idle task
    push(OP_CREATE, 8'd0,   9'd0);    // pid 2, top priority
    push(OP_CREATE, 8'd255, 9'd0);    // pid 3, lowest priority
    push(OP_START,  8'd0,   9'd0);    // preempt the idle task
    push(OP_START,  8'd0,   9'd0);    // running task is re-picked
    push(OP_EXIT,   8'd0,   9'd2);    // exit the running task: zombie stays current
    push(OP_TICK,   8'd0,   9'd0);    // zombie still counts down
    push(OP_EXIT,   8'd0,   9'd2);    // exit a zombie again
    push(OP_EXIT,   8'd0,   9'd511);  // unknown ids
    push(OP_EXIT,   8'd0,   9'd0);
    push(OP_EXIT,   8'd0,   9'd256);
    push(OP_CREATE, 8'd255, 9'd0);    // ties with the idle task
    push(OP_START,  8'd0,   9'd0);    // current is a zombie, pick among ready
    drain();
    write_slice(8'd0);
    push(OP_START,  8'd0,   9'd0);    // reload with a zero slice
    push(OP_TICK,   8'd0,   9'd0);    // expiry, same task wins the tie again
    push(OP_EXIT,   8'd0,   9'd1);
    push(OP_TICK,   8'd0,   9'd0);    // zombie expires and stays a zombie
    push(OP_EXIT,   8'd0,   9'd3);
    push(OP_EXIT,   8'd0,   9'd4);
    push(OP_TICK,   8'd0,   9'd0);    // expiry with nothing ready: go idle
    push(OP_TICK,   8'd0,   9'd0);    // idle tick, nothing to pick
    push(OP_START,  8'd0,   9'd0);    // start with nothing ready
    push(OP_CREATE, 8'd7,   9'd0);
    push(OP_TICK,   8'd0,   9'd0);    // idle tick dispatches the new task

    // Random phases; drain before every slice write.
    ph_slice[5] = $urandom_range(4, 40);
    ph_slice[6] = $urandom_range(0, 255);
    for (int p = 0; p < 8; p++) begin
      drain();
      write_slice(SLICE_W'(ph_slice[p]));
      tx_gaps_on  = (p != 4);
      rx_stall_on = (p != 4);
      for (int n = 0; n < ph_items[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < ph_tick[p]) op = OP_TICK;
        else if (r < ph_tick[p] + ph_create[p]) op = OP_CREATE;
        else if (r < ph_tick[p] + ph_create[p] + ph_exit[p]) op = OP_EXIT;
        else op = OP_START;
        // Cluster priorities now and then so ties are common.
        prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3))
                                    : PRIO_W'($urandom_range(0, 255));
        id_hi = (created + 1 > 256) ? 256 : created + 1;
        if (op == OP_EXIT && $urandom_range(0, 4) != 0) id = PID_W'($urandom_range(1, id_hi));
        else id = PID_W'($urandom_range(0, 511));
        push(op, prio, id);
      end
    end

    // Wind down: wait for outstanding results, then watch for strays.
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOTS + 16) @(posedge clk);
    @(negedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (pending == 0 && fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/pst_pkg.sv
design/pst_table.sv
design/priority_slice_task_scheduler.sv
design/pst_checker.sv
tb/sched_reply_scoreboard.sv
tb/tb_priority_slice_task_scheduler.sv
